### hdl/fljs_pkg.sv
// Shared types and constants for the flow latency and jitter statistics block.
package fljs_pkg;

    // Width of the delay and jitter sums.
    localparam int SUM_BITS = 64;

    // Controller states; each entry is read, its jitter formed, then written back.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RD_CLS  = 7'b0000010,
        S_JIT_CLS = 7'b0000100,
        S_UPD_CLS = 7'b0001000,
        S_RD_AGG  = 7'b0010000,
        S_JIT_AGG = 7'b0100000,
        S_UPD_AGG = 7'b1000000
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd_en;
        logic jit_en;
        logic commit;
        logic agg;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

### hdl/flow_latency_jitter_stats.sv
// The class result is registered into the output register at the class write-back, after the
// class read and jitter step; the aggregate result follows at the aggregate write-back. A new item
// is taken only once both are done: on the single-port entry memory the class and then the aggregate
// entry each take a read, a jitter step and a write-back. A stalled output holds the write-back state.
// Reset is asynchronous and active low; per-entry valid bits zero all counters at once,
// so there is no clearing pass and the block takes input in the first cycle after reset.
module flow_latency_jitter_stats
    import fljs_pkg::*;
#(
    parameter int FLOW_CLASSES = 6,
    parameter int TIME_BITS    = 48,
    parameter int COUNT_BITS   = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [$clog2(FLOW_CLASSES+1)-1:0]  flow_class,
    input  logic [TIME_BITS-1:0]               send_stamp,
    input  logic [TIME_BITS-1:0]               create_stamp,
    input  logic [TIME_BITS-1:0]               now_stamp,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [$clog2(FLOW_CLASSES+1)-1:0]  entry_index,
    output logic [COUNT_BITS-1:0]              sent_total,
    output logic [COUNT_BITS-1:0]              received_total,
    output logic [SUM_BITS-1:0]                delay_total,
    output logic [COUNT_BITS-1:0]              jitter_samples,
    output logic [SUM_BITS-1:0]                jitter_total,
    output logic [TIME_BITS-1:0]               jitter_peak,
    output logic [TIME_BITS-1:0]               latest_delay,
    output logic                               last
);

    localparam int IDX_BITS = $clog2(FLOW_CLASSES + 1);

    cmd_t    cmd;
    status_t status;

    fljs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fljs_datapath #(
        .FLOW_CLASSES (FLOW_CLASSES),
        .TIME_BITS    (TIME_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .IDX_BITS     (IDX_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .flow_class     (flow_class),
        .send_stamp     (send_stamp),
        .create_stamp   (create_stamp),
        .now_stamp      (now_stamp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_index    (entry_index),
        .sent_total     (sent_total),
        .received_total (received_total),
        .delay_total    (delay_total),
        .jitter_samples (jitter_samples),
        .jitter_total   (jitter_total),
        .jitter_peak    (jitter_peak),
        .latest_delay   (latest_delay),
        .last           (last)
    );

endmodule

### hdl/fljs_ctrl.sv
// Controller state machine sequencing the class and aggregate entry updates.
module fljs_ctrl
    import fljs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_RD_CLS;
                end
            end
            S_RD_CLS:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_JIT_CLS;
            end
            S_JIT_CLS:
            begin
                cmd.jit_en = 1'b1;
                state_next = S_UPD_CLS;
            end
            S_UPD_CLS:
            begin
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_RD_AGG;
                end
            end
            S_RD_AGG:
            begin
                cmd.agg    = 1'b1;
                cmd.rd_en  = 1'b1;
                state_next = S_JIT_AGG;
            end
            S_JIT_AGG:
            begin
                cmd.agg    = 1'b1;
                cmd.jit_en = 1'b1;
                state_next = S_UPD_AGG;
            end
            S_UPD_AGG:
            begin
                cmd.agg    = 1'b1;
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A result is only written back when the output register can take it.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("entry committed while output register busy");

    // Every accepted transfer is followed by the class entry read.
    a_latch_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (cmd.rd_en && !cmd.agg))
        else $error("class read did not follow accepted transfer");

    // Once the aggregate is committed the block takes input again.
    a_agg_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.agg) |=> !in_stall)
        else $error("input still stalled after aggregate commit");
`endif

endmodule

### hdl/fljs_datapath.sv
// Datapath: entry memory, delay and jitter arithmetic and the output register.
module fljs_datapath
    import fljs_pkg::*;
#(
    parameter int FLOW_CLASSES = 6,
    parameter int TIME_BITS    = 48,
    parameter int COUNT_BITS   = 32,
    parameter int IDX_BITS     = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  action,
    input  logic [IDX_BITS-1:0]   flow_class,
    input  logic [TIME_BITS-1:0]  send_stamp,
    input  logic [TIME_BITS-1:0]  create_stamp,
    input  logic [TIME_BITS-1:0]  now_stamp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_BITS-1:0]   entry_index,
    output logic [COUNT_BITS-1:0] sent_total,
    output logic [COUNT_BITS-1:0] received_total,
    output logic [SUM_BITS-1:0]   delay_total,
    output logic [COUNT_BITS-1:0] jitter_samples,
    output logic [SUM_BITS-1:0]   jitter_total,
    output logic [TIME_BITS-1:0]  jitter_peak,
    output logic [TIME_BITS-1:0]  latest_delay,
    output logic                  last
);

    localparam int ENTRIES = FLOW_CLASSES + 1;
    localparam logic [IDX_BITS-1:0] AGG_IDX = IDX_BITS'(FLOW_CLASSES);
    localparam logic [IDX_BITS-1:0] TOP_CLS = IDX_BITS'(FLOW_CLASSES - 1);

    typedef struct packed {
        logic [COUNT_BITS-1:0] sent;
        logic [COUNT_BITS-1:0] recv;
        logic [COUNT_BITS-1:0] jcnt;
        logic [SUM_BITS-1:0]   dsum;
        logic [SUM_BITS-1:0]   jsum;
        logic [TIME_BITS-1:0]  jmax;
        logic [TIME_BITS-1:0]  prev;
        logic                  pvalid;
    } rec_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

    rec_t                 mem [ENTRIES];
    logic [ENTRIES-1:0]   written_reg;
    rec_t                 rd_data_reg;
    logic                 rd_hit_reg;
    logic                 action_reg;
    logic [IDX_BITS-1:0]  cls_reg;
    logic [TIME_BITS-1:0] delay_reg;
    logic [TIME_BITS-1:0] jitter_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS:0]   delay_diff;
    logic [TIME_BITS:0]   jit_diff;
    logic [IDX_BITS-1:0]  addr;
    rec_t                 cur;
    rec_t                 upd;

    // A zero send stamp falls back to the creation stamp; a stamp in the future clamps the delay to zero.
    assign stamp      = (send_stamp != '0) ? send_stamp : create_stamp;
    assign delay_diff = {1'b0, now_stamp} - {1'b0, stamp};
    assign addr       = cmd.agg ? AGG_IDX : cls_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            cls_reg    <= (flow_class >= AGG_IDX) ? TOP_CLS : flow_class;
            delay_reg  <= delay_diff[TIME_BITS] ? '0 : delay_diff[TIME_BITS-1:0];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
            rd_hit_reg  <= written_reg[addr];
        end
        if (cmd.commit)
        begin
            mem[addr] <= upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (cmd.commit)
        begin
            written_reg[addr] <= 1'b1;
        end
    end

    assign cur      = rd_hit_reg ? rd_data_reg : '0;
    assign jit_diff = {1'b0, delay_reg} - {1'b0, cur.prev};

    always_ff @(posedge clk)
    begin
        if (cmd.jit_en)
        begin
            jitter_reg <= jit_diff[TIME_BITS] ? cur.prev - delay_reg : jit_diff[TIME_BITS-1:0];
        end
    end

    always_comb
    begin
        upd = cur;
        if (!action_reg)
        begin
            upd.sent = sat_inc(cur.sent);
        end
        else
        begin
            upd.recv = sat_inc(cur.recv);
            upd.dsum = sat_add(cur.dsum, SUM_BITS'(delay_reg));
            if (cur.pvalid)
            begin
                upd.jcnt = sat_inc(cur.jcnt);
                upd.jsum = sat_add(cur.jsum, SUM_BITS'(jitter_reg));
                if (jitter_reg > cur.jmax)
                begin
                    upd.jmax = jitter_reg;
                end
            end
            upd.prev   = delay_reg;
            upd.pvalid = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entry_index    <= addr;
            sent_total     <= upd.sent;
            received_total <= upd.recv;
            delay_total    <= upd.dsum;
            jitter_samples <= upd.jcnt;
            jitter_total   <= upd.jsum;
            jitter_peak    <= upd.jmax;
            latest_delay   <= upd.prev;
            last           <= cmd.agg;
        end
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule
